// ===== sv/rbg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbg_pkg
// shared constants, control word types and microprogram for the ring bead step
// ----------------------------------------------------------------------------
package rbg_pkg;

  localparam int BEADS = 5;
  localparam int LEDS  = 60;

  localparam int BIDX_W = (BEADS > 1) ? $clog2(BEADS) : 1;
  localparam int POS_W  = 16;
  localparam int VEL_W  = 16;
  localparam int CFG_W  = 15;
  localparam int CIDX_W = 2;
  localparam int BEAD_W = 4;
  localparam int LED_W  = 6;
  localparam int PULL_W = 9;
  localparam int SUM_W  = 17;
  localparam int SEG_W  = 10 + $clog2(LEDS + 1);
  localparam int LEDR_W = SEG_W - 9;
  localparam int PC_W   = 4;

  localparam logic [POS_W-1:0] LED_SPACING  = POS_W'(65536 / LEDS);
  localparam int               BEAD_SPACING = 65536 / BEADS;
  localparam logic [POS_W-1:0] HALF_TURN    = POS_W'(32768);
  localparam logic [SEG_W:0]   LED_ROUND    = (SEG_W + 1)'(512);

  localparam logic [CFG_W-1:0] MAX_SPEED_RST = CFG_W'(10000);
  localparam logic [CFG_W-1:0] DAMPING_RST   = CFG_W'(26214);

  // register indexes on the config port
  localparam logic [CIDX_W-1:0] REG_MAX_SPEED = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_DAMPING   = CIDX_W'(1);

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_ADV_RD,
    OP_ADV_PULL,
    OP_ADV_VEL,
    OP_ADV_MOVE,
    OP_SEP_RDA,
    OP_SEP_RDB,
    OP_SEP_CMP,
    OP_SEP_DMA,
    OP_SEP_WR,
    OP_OUT_MUL,
    OP_OUT_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_HOLD_IN,
    JC_LOOP_K,
    JC_LOOP_PAIR,
    JC_EMIT
  } jc_t;

  typedef struct packed {
    op_t             op;
    jc_t             jc;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic k_last;
    logic pair_last;
  } seq_st_t;

  // microprogram entry points
  localparam logic [PC_W-1:0] A_IDLE = PC_W'(0);
  localparam logic [PC_W-1:0] A_ADV  = PC_W'(1);
  localparam logic [PC_W-1:0] A_SEP  = PC_W'(5);
  localparam logic [PC_W-1:0] A_OUT  = PC_W'(10);

  function automatic ctl_t prog_rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      4'd0:    w = '{OP_WAIT,     JC_HOLD_IN,   A_IDLE};
      4'd1:    w = '{OP_ADV_RD,   JC_NEXT,      A_IDLE};
      4'd2:    w = '{OP_ADV_PULL, JC_NEXT,      A_IDLE};
      4'd3:    w = '{OP_ADV_VEL,  JC_NEXT,      A_IDLE};
      4'd4:    w = '{OP_ADV_MOVE, JC_LOOP_K,    A_ADV};
      4'd5:    w = '{OP_SEP_RDA,  JC_NEXT,      A_IDLE};
      4'd6:    w = '{OP_SEP_RDB,  JC_NEXT,      A_IDLE};
      4'd7:    w = '{OP_SEP_CMP,  JC_NEXT,      A_IDLE};
      4'd8:    w = '{OP_SEP_DMA,  JC_NEXT,      A_IDLE};
      4'd9:    w = '{OP_SEP_WR,   JC_LOOP_PAIR, A_SEP};
      4'd10:   w = '{OP_OUT_MUL,  JC_NEXT,      A_IDLE};
      4'd11:   w = '{OP_OUT_EMIT, JC_EMIT,      A_OUT};
      default: w = '{OP_WAIT,     JC_HOLD_IN,   A_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/ring_bead_gravity_collision_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_bead_gravity_collision_step
// gravity, collision and led mapping for beads on a ring, one tick per beat
// ----------------------------------------------------------------------------
// usage
//   in_*  : one beat per tick carries the 16-bit down angle (65536 per turn)
//   out_* : BEADS result beats per tick, in bead order, each with the bead
//           index and its led index; out_last marks the final bead
//   cfg_* : max_speed (index 0) and damping (index 1), write only, taken
//           when cfg_we is high; write them only while the block is idle
// sequence
//   each tick runs through the microprogram from acceptance until in_ready
//   is high again: one idle step, four steps per bead for motion, five per
//   neighbor pair (separation plus two passes through the one damping
//   multiplier) and two per bead result (led multiply, then emit)
// reset
//   beads return to evenly spaced positions at rest, registers to defaults
// backpressure
//   a result waits in the output register while out_ready is low; the
//   sequencer holds on the emit step until it drains
// ----------------------------------------------------------------------------
module ring_bead_gravity_collision_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbg_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rbg_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rbg_pkg::POS_W-1:0]     in_down_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rbg_pkg::BEAD_W-1:0]    out_bead,
  output logic [rbg_pkg::LED_W-1:0]     out_led,
  output logic                          out_last
);
  import rbg_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] max_speed_r;
  logic [CFG_W-1:0] damping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      damping_r   <= DAMPING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SPEED: max_speed_r <= cfg_wdata;
        REG_DAMPING:   damping_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control word from the sequencer, status back from the datapath
  ctl_t    ctl;
  seq_st_t st;

  rbg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  rbg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .st            (st),
    .max_speed     (max_speed_r),
    .damping       (damping_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_down_angle (in_down_angle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bead      (out_bead),
    .out_led       (out_led),
    .out_last      (out_last)
  );

`ifndef SYNTHESIS
  // an accepted tick starts the program, so the input closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after accepting a tick");

  // back at idle, only the final bead result may still be pending
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("idle while non-final results pending");

  // the final marker goes with the highest bead index
  a_last_bead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_bead == BEAD_W'(BEADS - 1))
    else $error("last marker on wrong bead");

  // led index stays on the ring
  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_led < LED_W'(LEDS))
    else $error("led index out of range");
`endif

endmodule

// ===== sv/rbg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbg_seq
// step counter, control store lookup and conditional jumps
// ----------------------------------------------------------------------------
module rbg_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  rbg_pkg::seq_st_t st,
  output rbg_pkg::ctl_t    ctl
);
  import rbg_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic [PC_W-1:0] pc_inc;

  assign ctl    = prog_rom(pc_r);
  assign pc_inc = pc_r + PC_W'(1);

  always_comb begin
    case (ctl.jc)
      JC_NEXT:      pc_nxt = pc_inc;
      JC_HOLD_IN:   pc_nxt = st.in_fire ? pc_inc : pc_r;
      JC_LOOP_K:    pc_nxt = st.k_last ? pc_inc : ctl.target;
      JC_LOOP_PAIR: pc_nxt = st.pair_last ? pc_inc : ctl.target;
      JC_EMIT: begin
        if (!st.out_free) pc_nxt = pc_r;
        else if (st.k_last) pc_nxt = A_IDLE;
        else pc_nxt = ctl.target;
      end
      default:      pc_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== sv/rbg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbg_dp
// bead register file, working registers, shared multiplier and result register
// ----------------------------------------------------------------------------
module rbg_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rbg_pkg::ctl_t                    ctl,
  output rbg_pkg::seq_st_t                 st,
  input  logic [rbg_pkg::CFG_W-1:0]        max_speed,
  input  logic [rbg_pkg::CFG_W-1:0]        damping,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rbg_pkg::POS_W-1:0]        in_down_angle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rbg_pkg::BEAD_W-1:0]       out_bead,
  output logic [rbg_pkg::LED_W-1:0]        out_led,
  output logic                             out_last
);
  import rbg_pkg::*;

  // bead state
  logic [POS_W-1:0]        pos_r [BEADS];
  logic signed [VEL_W-1:0] vel_r [BEADS];

  // control registers
  logic [BIDX_W-1:0] k_r, ia_r, ib_r;
  logic              first_r;
  logic              out_valid_r;

  // working registers
  logic [POS_W-1:0]        down_r;
  logic [POS_W-1:0]        pa_r, pb_r;
  logic signed [VEL_W-1:0] va_r, vb_r, ma_r;
  logic signed [PULL_W-1:0] pull_r;
  logic                    coll_r;
  logic [SEG_W-1:0]        seg_r;
  logic [BEAD_W-1:0]       out_bead_r;
  logic [LED_W-1:0]        out_led_r;
  logic                    out_last_r;

  logic in_fire, out_free, k_last, pair_last, emit;
  logic [BIDX_W-1:0] k_nxt;

  assign in_ready  = (ctl.op == OP_WAIT);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign k_last    = (k_r == BIDX_W'(BEADS - 1));
  assign pair_last = !first_r && (ib_r == BIDX_W'(BEADS - 1));
  assign k_nxt     = k_last ? '0 : k_r + BIDX_W'(1);
  assign emit      = (ctl.op == OP_OUT_EMIT) && out_free;

  assign st = '{in_fire: in_fire, out_free: out_free, k_last: k_last,
                pair_last: pair_last};

  // gravity pull from wrapped angle difference
  logic [POS_W-1:0]         d, dneg;
  logic signed [PULL_W-1:0] pull_nxt;
  always_comb begin
    d    = down_r - pa_r;
    dneg = '0 - d;
    if (d == HALF_TURN) pull_nxt = '0;
    else if (d[POS_W-1]) pull_nxt = -$signed({1'b0, dneg[POS_W-1:8]});
    else pull_nxt = $signed({1'b0, d[POS_W-1:8]});
  end

  // velocity sum and clamp
  logic signed [SUM_W-1:0] vsum, lim, nlim;
  logic signed [VEL_W-1:0] vclamp;
  always_comb begin
    vsum = {va_r[VEL_W-1], va_r} + {{(SUM_W - PULL_W){pull_r[PULL_W-1]}}, pull_r};
    lim  = {{(SUM_W - CFG_W){1'b0}}, max_speed};
    nlim = -lim;
    if (vsum > lim) vclamp = lim[VEL_W-1:0];
    else if (vsum < nlim) vclamp = nlim[VEL_W-1:0];
    else vclamp = vsum[VEL_W-1:0];
  end

  // position move by |v| >> 4
  logic [VEL_W-1:0] vmag;
  logic [POS_W-1:0] vstep, move_pos;
  always_comb begin
    vmag     = va_r[VEL_W-1] ? -va_r : va_r;
    vstep    = vmag >> 4;
    move_pos = va_r[VEL_W-1] ? pa_r - vstep : pa_r + vstep;
  end

  // neighbor separation and collision test
  logic [POS_W-1:0]        dj, di, pb_sep;
  logic                    c1, c2, no_coll;
  logic signed [VEL_W-1:0] vl, vr;
  always_comb begin
    dj = pb_r - pa_r;
    di = pa_r - pb_r;
    c1 = (dj < LED_SPACING);
    c2 = !c1 && (di < LED_SPACING);
    if (c1) pb_sep = pa_r + LED_SPACING;
    else if (c2) pb_sep = pa_r - LED_SPACING;
    else pb_sep = pb_r;
    vl = c1 ? va_r : vb_r;
    vr = c1 ? vb_r : va_r;
    no_coll = ((vl[VEL_W-1] || vl == '0) && (vr > vl)) ||
              (!vr[VEL_W-1] && (vl < vr));
  end

  // shared damping multiplier, q15
  logic signed [VEL_W-1:0]   mul_a;
  logic signed [2*VEL_W-1:0] prod;
  logic signed [VEL_W-1:0]   damp_v;
  always_comb begin
    mul_a  = (ctl.op == OP_SEP_DMA) ? vb_r : va_r;
    prod   = mul_a * $signed({1'b0, damping});
    damp_v = prod[30:15];
  end

  // led index mapping
  logic [SEG_W:0]    led_sum;
  logic [LEDR_W-1:0] led_raw;
  logic [LED_W-1:0]  led_v;
  always_comb begin
    led_sum = {1'b0, seg_r} + LED_ROUND;
    led_raw = led_sum[SEG_W:10];
    led_v   = (led_raw == LEDR_W'(LEDS)) ? '0 : LED_W'(led_raw);
  end

  // bead register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BEADS; i++) begin
        pos_r[i] <= POS_W'(i * BEAD_SPACING);
        vel_r[i] <= '0;
      end
    end else begin
      case (ctl.op)
        OP_ADV_MOVE: begin
          pos_r[k_r] <= move_pos;
          vel_r[k_r] <= va_r;
        end
        OP_SEP_WR: begin
          pos_r[ib_r] <= pb_r;
          vel_r[ia_r] <= coll_r ? ma_r : va_r;
          vel_r[ib_r] <= coll_r ? damp_v : vb_r;
        end
        default: ;
      endcase
    end
  end

  // loop indexes and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      ia_r        <= '0;
      ib_r        <= BIDX_W'(BEADS - 1);
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.op)
        OP_WAIT: begin
          if (in_fire) begin
            k_r     <= '0;
            ia_r    <= '0;
            ib_r    <= BIDX_W'(BEADS - 1);
            first_r <= 1'b1;
          end
        end
        OP_ADV_MOVE: k_r <= k_nxt;
        OP_SEP_WR: begin
          first_r <= 1'b0;
          if (first_r) begin
            ia_r <= '0;
            ib_r <= BIDX_W'(1);
          end else begin
            ia_r <= ia_r + BIDX_W'(1);
            ib_r <= ib_r + BIDX_W'(1);
          end
        end
        OP_OUT_EMIT: if (out_free) k_r <= k_nxt;
        default: ;
      endcase
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_WAIT:     if (in_fire) down_r <= in_down_angle;
      OP_ADV_RD: begin
        pa_r <= pos_r[k_r];
        va_r <= vel_r[k_r];
      end
      OP_ADV_PULL: pull_r <= pull_nxt;
      OP_ADV_VEL:  va_r <= vclamp;
      OP_SEP_RDA: begin
        pa_r <= pos_r[ia_r];
        va_r <= vel_r[ia_r];
      end
      OP_SEP_RDB: begin
        pb_r <= pos_r[ib_r];
        vb_r <= vel_r[ib_r];
      end
      OP_SEP_CMP: begin
        pb_r   <= pb_sep;
        coll_r <= (c1 || c2) && !no_coll;
      end
      OP_SEP_DMA:  ma_r <= damp_v;
      OP_OUT_MUL:  seg_r <= SEG_W'(pos_r[k_r][POS_W-1:6]) * SEG_W'(LEDS);
      default: ;
    endcase
    if (emit) begin
      out_bead_r <= BEAD_W'(k_r);
      out_led_r  <= led_v;
      out_last_r <= k_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bead  = out_bead_r;
  assign out_led   = out_led_r;
  assign out_last  = out_last_r;

endmodule
